### design/mh2_pkg.sv
// mh2_pkg: shared constants and types for the streaming murmurhash2 block
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package mh2_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned VB_W   = 3;

  localparam logic [WORD_W-1:0] MIX_MUL = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  typedef enum logic [1:0] {
    MUL_KEY_A = 2'd0,
    MUL_KEY_B = 2'd1,
    MUL_HASH  = 2'd2,
    MUL_AVAL  = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_out;
  } mh2_cmd_t;

endpackage

`default_nettype wire

### design/mh2_if.sv
// mh2_if: valid/ready channel interfaces for input words, results and seed writes
// depends on mh2_pkg for widths
`default_nettype none

interface mh2_in_if;
  logic                           valid;
  logic                           ready;
  logic [mh2_pkg::WORD_W-1:0]     data_word;
  logic [mh2_pkg::VB_W-1:0]       valid_bytes;
  logic                           first_word;
  logic                           last_word;
  logic [mh2_pkg::WORD_W-1:0]     message_length;

  modport source (output valid, data_word, valid_bytes, first_word, last_word,
                  message_length, input ready);
  modport sink (input valid, data_word, valid_bytes, first_word, last_word,
                message_length, output ready);
endinterface

interface mh2_out_if;
  logic                       valid;
  logic                       ready;
  logic [mh2_pkg::WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

interface mh2_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mh2_pkg::WORD_W-1:0] seed;

  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface

`default_nettype wire

### design/mh2_ctrl.sv
// mh2_ctrl: state machine sequencing the shared multiplier per word and the result
// depends on mh2_pkg for the command struct and multiplier selects
`default_nettype none

module mh2_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [mh2_pkg::VB_W-1:0] in_valid_bytes,
  input  wire logic                     in_last_word,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output mh2_pkg::mh2_cmd_t             cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_KEY_A = 6'b000010,
    ST_KEY_B = 6'b000100,
    ST_HASH  = 6'b001000,
    ST_AVAL  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{load_in: 1'b0, mul_en: 1'b0, mul_sel: mh2_pkg::MUL_KEY_A,
                      load_out: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          last_nxt    = in_last_word;
          case (in_valid_bytes) inside
            3'd0: begin
              state_nxt = in_last_word ? ST_AVAL : ST_IDLE;
            end
            [3'd1:3'd3]: begin
              state_nxt = ST_HASH;
            end
            default: begin
              state_nxt = ST_KEY_A;
            end
          endcase
        end
      end
      ST_KEY_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mh2_pkg::MUL_KEY_A;
        state_nxt   = ST_KEY_B;
      end
      ST_KEY_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mh2_pkg::MUL_KEY_B;
        state_nxt   = ST_HASH;
      end
      ST_HASH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mh2_pkg::MUL_HASH;
        state_nxt   = last_r ? ST_AVAL : ST_IDLE;
      end
      ST_AVAL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mh2_pkg::MUL_AVAL;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mh2_dp.sv
// mh2_dp: hash and key registers around one shared 32x32 multiplier, seed and result
// depends on mh2_pkg for constants and the command struct
`default_nettype none

module mh2_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mh2_pkg::mh2_cmd_t          cmd,
  input  wire logic                       cfg_write,
  input  wire logic [mh2_pkg::WORD_W-1:0] cfg_seed,
  input  wire logic [mh2_pkg::WORD_W-1:0] in_data_word,
  input  wire logic [mh2_pkg::VB_W-1:0]   in_valid_bytes,
  input  wire logic                       in_first_word,
  input  wire logic [mh2_pkg::WORD_W-1:0] in_message_length,
  output logic [mh2_pkg::WORD_W-1:0]      hash_value
);

  logic [mh2_pkg::WORD_W-1:0] seed_r;
  logic [mh2_pkg::WORD_W-1:0] h_r, h_nxt;
  logic [mh2_pkg::WORD_W-1:0] k_r, k_nxt;
  logic [mh2_pkg::WORD_W-1:0] res_r;
  logic [mh2_pkg::WORD_W-1:0] h_start;
  logic [mh2_pkg::WORD_W-1:0] tail_mask;
  logic [mh2_pkg::WORD_W-1:0] mul_a;
  logic [mh2_pkg::WORD_W-1:0] prod;

  assign h_start = in_first_word ? (seed_r ^ in_message_length) : h_r;

  always_comb begin
    case (in_valid_bytes) inside
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = '0;
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      mh2_pkg::MUL_HASH: mul_a = h_r;
      mh2_pkg::MUL_AVAL: mul_a = h_r ^ (h_r >> mh2_pkg::FIN_SHIFT_A);
      default:           mul_a = k_r;
    endcase
  end

  // low word of the product only, arithmetic is modulo 2^32
  assign prod = mul_a * mh2_pkg::MIX_MUL;

  always_comb begin
    h_nxt = h_r;
    k_nxt = k_r;
    if (cmd.load_in) begin
      case (in_valid_bytes) inside
        [3'd1:3'd3]: begin
          h_nxt = h_start ^ (in_data_word & tail_mask);
          k_nxt = '0;
        end
        default: begin
          h_nxt = h_start;
          k_nxt = in_data_word;
        end
      endcase
    end else if (cmd.mul_en) begin
      case (cmd.mul_sel)
        mh2_pkg::MUL_KEY_A: k_nxt = prod ^ (prod >> mh2_pkg::MIX_SHIFT);
        mh2_pkg::MUL_KEY_B: k_nxt = prod;
        mh2_pkg::MUL_HASH:  h_nxt = prod ^ k_r;
        default:            k_nxt = prod ^ (prod >> mh2_pkg::FIN_SHIFT_B);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      h_r    <= '0;
    end else begin
      if (cfg_write) begin
        seed_r <= cfg_seed;
      end
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.load_out) begin
      res_r <= k_r;
    end
  end

  assign hash_value = res_r;

endmodule

`default_nettype wire

### design/murmur2_hash_stream.sv
// murmur2_hash_stream: streaming 32-bit murmurhash2 over little-endian message words
// depends on mh2_pkg, the channel interfaces in mh2_if, mh2_ctrl and mh2_dp
//
// channels: in_chan carries one message word per transaction with its valid byte
// count, first/last marks and, on the first word, the total byte length.
// out_chan carries one hash_value per message, after the last word.
// cfg_chan writes the seed; it is always ready and takes effect for the next
// message that starts with a first word.
// timing: one shared 32x32 multiplier does all mixing, one product per cycle.
// a full word passes through the two key multiplies and the hash multiply before
// the next ready, a tail word of 1 to 3 bytes only through the hash multiply, and
// a word with no valid bytes through none. a last word then adds the avalanche
// multiply and the output load before the hash is offered on out_chan.
// the result sits in an output register; if the receiver stalls, the block
// still finishes the next message's words and waits only when it has a second
// result to deliver.
// reset: synchronous active-low rst_n clears the seed, the running hash and
// the controller; no result is pending afterwards.
`default_nettype none

module murmur2_hash_stream (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mh2_in_if.sink     in_chan,
  mh2_out_if.source  out_chan,
  mh2_cfg_if.sink    cfg_chan
);

  mh2_pkg::mh2_cmd_t cmd;

  assign cfg_chan.ready = 1'b1;

  mh2_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_valid_bytes (in_chan.valid_bytes),
    .in_last_word   (in_chan.last_word),
    .in_ready       (in_chan.ready),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .cmd            (cmd)
  );

  mh2_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_write         (cfg_chan.valid),
    .cfg_seed          (cfg_chan.seed),
    .in_data_word      (in_chan.data_word),
    .in_valid_bytes    (in_chan.valid_bytes),
    .in_first_word     (in_chan.first_word),
    .in_message_length (in_chan.message_length),
    .hash_value        (out_chan.hash_value)
  );

endmodule

`default_nettype wire

### verif/mh2_hash_checker.sv
// mh2_hash_checker: watches the input, result and seed channels of murmur2_hash_stream,
// predicts each message hash and compares it with the delivered hash_value
// depends on mh2_pkg and the channel interfaces in mh2_if
module mh2_hash_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mh2_in_if           in_mon,
  mh2_out_if          out_mon,
  mh2_cfg_if          cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned hashes_pending,
  output int unsigned hashes_checked
);

  logic [mh2_pkg::WORD_W-1:0] seed_q;
  logic [mh2_pkg::WORD_W-1:0] hash_q;
  logic [mh2_pkg::WORD_W-1:0] hashes_due[$];
  int unsigned                fail_total;
  int unsigned                check_total;

  function automatic logic [mh2_pkg::WORD_W-1:0] fold_word(
      logic [mh2_pkg::WORD_W-1:0] h, logic [mh2_pkg::WORD_W-1:0] k);
    logic [mh2_pkg::WORD_W-1:0] m;
    m = k * mh2_pkg::MIX_MUL;
    m = m ^ (m >> mh2_pkg::MIX_SHIFT);
    m = m * mh2_pkg::MIX_MUL;
    h = h * mh2_pkg::MIX_MUL;
    return h ^ m;
  endfunction

  function automatic logic [mh2_pkg::WORD_W-1:0] fold_tail(
      logic [mh2_pkg::WORD_W-1:0] h, logic [mh2_pkg::WORD_W-1:0] w,
      logic [mh2_pkg::VB_W-1:0] n);
    logic [mh2_pkg::WORD_W-1:0] mask;
    case (n)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      default: mask = 32'h00ff_ffff;
    endcase
    h = h ^ (w & mask);
    return h * mh2_pkg::MIX_MUL;
  endfunction

  function automatic logic [mh2_pkg::WORD_W-1:0] finalize_hash(
      logic [mh2_pkg::WORD_W-1:0] h);
    h = h ^ (h >> mh2_pkg::FIN_SHIFT_A);
    h = h * mh2_pkg::MIX_MUL;
    h = h ^ (h >> mh2_pkg::FIN_SHIFT_B);
    return h;
  endfunction

  always @(posedge clk) begin : watch
    logic [mh2_pkg::WORD_W-1:0] h;
    logic [mh2_pkg::VB_W-1:0]   nb;
    logic [mh2_pkg::WORD_W-1:0] want;
    if (!rst_n) begin
      seed_q = '0;
      hash_q = '0;
      hashes_due.delete();
      fail_total = 0;
      check_total = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        seed_q = cfg_mon.seed;
      end
      if (in_mon.valid && in_mon.ready) begin
        h = hash_q;
        nb = in_mon.valid_bytes;
        if (in_mon.first_word) begin
          h = seed_q ^ in_mon.message_length;
        end
        // counts above four mean a full word
        if (nb > 3'd4) begin
          nb = 3'd4;
        end
        if (nb == 3'd4) begin
          h = fold_word(h, in_mon.data_word);
        end else if (nb != 3'd0) begin
          h = fold_tail(h, in_mon.data_word, nb);
        end
        hash_q = h;
        if (in_mon.last_word) begin
          hashes_due.push_back(finalize_hash(h));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (hashes_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual hash_value %08h",
                   $time, out_mon.hash_value);
          fail_total++;
        end else begin
          want = hashes_due.pop_front();
          if (out_mon.hash_value !== want) begin
            $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                     $time, want, out_mon.hash_value);
            fail_total++;
          end
          check_total++;
        end
      end
    end
    mismatch_count <= fail_total;
    hashes_pending <= hashes_due.size();
    hashes_checked <= check_total;
  end

endmodule

### verif/tb_murmur2_hash_stream.sv
// tb_murmur2_hash_stream: stimulus and verdict for the streaming murmurhash2 block,
// directed corner messages then random messages and noise under varying stalls
// depends on mh2_pkg, mh2_if, murmur2_hash_stream and mh2_hash_checker
module tb_murmur2_hash_stream;

  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned WORDS_PER_PHASE = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned QUIET_LIMIT     = 3000;

  logic clk = 1'b0;
  logic rst_n;

  mh2_in_if  in_chan ();
  mh2_out_if out_chan ();
  mh2_cfg_if cfg_chan ();

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_off_requests = 0;
  int unsigned words_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned seeds_written = 0;
  int unsigned mismatch_count;
  int unsigned hashes_pending;
  int unsigned hashes_checked;

  murmur2_hash_stream u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  mh2_hash_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_mon        (cfg_chan),
    .mismatch_count (mismatch_count),
    .hashes_pending (hashes_pending),
    .hashes_checked (hashes_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : receiver
    int unsigned served;
    served = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_requests != served) begin
        served = hold_off_requests;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_word(input logic [mh2_pkg::WORD_W-1:0] data,
                           input logic [mh2_pkg::VB_W-1:0] nbytes,
                           input logic first, input logic last,
                           input logic [mh2_pkg::WORD_W-1:0] length);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.data_word      <= data;
    in_chan.valid_bytes    <= nbytes;
    in_chan.first_word     <= first;
    in_chan.last_word      <= last;
    in_chan.message_length <= length;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
  endtask

  task automatic wait_hashes();
    do @(posedge clk); while (hashes_pending != 0);
  endtask

  task automatic write_seed(input logic [mh2_pkg::WORD_W-1:0] value);
    in_chan.valid <= 1'b0;
    wait_hashes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.seed  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    seeds_written++;
  endtask

  task automatic send_message(input int unsigned total_bytes,
                              input logic [mh2_pkg::WORD_W-1:0] length);
    int unsigned full;
    int unsigned tail;
    full = total_bytes / 4;
    tail = total_bytes % 4;
    if (total_bytes == 0) begin
      send_word($urandom, 3'd0, 1'b1, 1'b1, length);
    end else begin
      for (int unsigned i = 0; i < full; i++) begin
        send_word($urandom, 3'd4, i == 0, (i == full - 1) && (tail == 0), length);
      end
      if (tail != 0) begin
        send_word($urandom, mh2_pkg::VB_W'(tail), full == 0, 1'b1, length);
      end
    end
    messages_sent++;
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                           input logic [mh2_pkg::WORD_W-1:0] seed_value,
                           input bit with_hold_off);
    int unsigned start;
    int unsigned nbytes;
    bit          held;
    bit          paused;
    write_seed(seed_value);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    start = words_sent;
    held = 1'b0;
    paused = 1'b0;
    while (words_sent - start < WORDS_PER_PHASE) begin
      if (with_hold_off && !held && words_sent - start >= 40) begin
        hold_off_requests++;
        held = 1'b1;
      end
      if (!paused && words_sent - start >= WORDS_PER_PHASE / 2) begin
        // sender pauses until the block has drained
        in_chan.valid <= 1'b0;
        wait_hashes();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_word($urandom, mh2_pkg::VB_W'($urandom_range(7)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom);
      end else begin
        nbytes = ($urandom_range(99) < 10) ? $urandom_range(120) : $urandom_range(24);
        send_message(nbytes, ($urandom_range(99) < 10) ? $urandom : nbytes);
      end
    end
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data_word <= '0;
    in_chan.valid_bytes <= '0;
    in_chan.first_word <= 1'b0;
    in_chan.last_word <= 1'b0;
    in_chan.message_length <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.seed <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 30;
    sink_idle_pct = 30;
    // no first word after reset, then a last word with no bytes
    send_word(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'h0);
    send_word(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'h0);
    // empty messages at both length extremes
    send_word(32'h1234_5678, 3'd0, 1'b1, 1'b1, 32'h0);
    send_word(32'hdead_beef, 3'd0, 1'b1, 1'b1, 32'hffff_ffff);
    write_seed(32'hffff_ffff);
    // single-word messages of byte counts 1 to 7 with high bits set past and inside the valid bytes
    send_word(32'hffff_ff80, 3'd1, 1'b1, 1'b1, 32'd1);
    send_word(32'hffff_80ff, 3'd2, 1'b1, 1'b1, 32'd2);
    send_word(32'hff80_ffff, 3'd3, 1'b1, 1'b1, 32'd3);
    send_word(32'h8000_0000, 3'd4, 1'b1, 1'b1, 32'd4);
    send_word(32'h7fff_ffff, 3'd5, 1'b1, 1'b1, 32'd4);
    send_word(32'h0000_0001, 3'd6, 1'b1, 1'b1, 32'd4);
    send_word(32'hffff_fffe, 3'd7, 1'b1, 1'b1, 32'd4);
    // short word in the middle of a message
    send_word(32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'd11);
    send_word(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'd11);
    send_word(32'ha5a5_a5a5, 3'd2, 1'b0, 1'b0, 32'd11);
    send_word(32'h5a5a_5a5a, 3'd4, 1'b0, 1'b1, 32'd11);
    // first word and a middle word without bytes
    send_word($urandom, 3'd0, 1'b1, 1'b0, 32'd7);
    send_word($urandom, 3'd0, 1'b0, 1'b0, 32'd0);
    send_word($urandom, 3'd3, 1'b0, 1'b1, 32'd7);

    run_phase(16, 84, $urandom, 1'b1);
    run_phase(84, 16, 32'h0000_0000, 1'b0);
    run_phase(0, 0, $urandom, 1'b1);

    in_chan.valid <= 1'b0;
    wait_hashes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words in %0d messages plus noise, %0d hashes compared, %0d seed writes",
             words_sent, messages_sent, hashes_checked, seeds_written);
    $display("stall mixes 16/84, 84/16 and none, with %0d long receiver hold-offs",
             hold_off_requests);
    if (mismatch_count == 0 && hashes_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### murmur2_hash_stream.f
design/mh2_pkg.sv
design/mh2_if.sv
design/mh2_ctrl.sv
design/mh2_dp.sv
design/murmur2_hash_stream.sv
verif/mh2_hash_checker.sv
verif/tb_murmur2_hash_stream.sv
